// ===== rtl/svf_pkg.sv =====
// Shared types, constants and helper functions for the seven-segment value formatter.
// No dependencies; every other file in rtl/ imports this package.
package svf_pkg;

  localparam int unsigned ValueW  = 17;
  localparam int unsigned DigitW  = 4;
  localparam int unsigned SelW    = 4;
  localparam int unsigned SegW    = 7;
  localparam int unsigned Rem1W   = 14;  // remainder below 10000
  localparam int unsigned Rem2W   = 10;  // remainder below 1000
  localparam int unsigned Rem3W   = 7;   // remainder below 100
  localparam int unsigned NumFrames = 4;
  localparam int unsigned FrameIdxW = 2;

  localparam logic [ValueW-1:0] SatMax = ValueW'(99999);
  localparam logic [ValueW-1:0] Unit10000 = ValueW'(10000);
  localparam logic [ValueW-1:0] Unit1000  = ValueW'(1000);
  localparam logic [ValueW-1:0] Unit100   = ValueW'(100);
  localparam logic [ValueW-1:0] Unit10    = ValueW'(10);

  localparam logic [SegW-1:0] SegBlank = 7'h00;
  localparam logic [SegW-1:0] SegCOnly = 7'h04;

  localparam logic [0:0] ModeTemp  = 1'b0;
  localparam logic [0:0] ModeAngle = 1'b1;

  typedef struct packed {
    logic [DigitW-1:0] hun;
    logic [DigitW-1:0] ten;
    logic [DigitW-1:0] one;
    logic [Rem3W-1:0]  rem3;
  } digits_t;

  typedef struct packed {
    logic [SelW-1:0] sel;
    logic [SegW-1:0] seg;
    logic            dp;
    logic            deg;
  } frame_t;

  // Truncated quotient x / unit for quotients 0..9: count the multiples not above x.
  function automatic logic [DigitW-1:0] digit_of(input logic [ValueW-1:0] x,
                                                 input logic [ValueW-1:0] unit);
    logic [DigitW-1:0] d;
    d = '0;
    for (int k = 1; k < 10; k++) begin
      if (x >= ValueW'(k) * unit) d = DigitW'(k);
    end
    return d;
  endfunction

  function automatic logic [SegW-1:0] seg_of(input logic [DigitW-1:0] d);
    logic [SegW-1:0] s;
    unique case (d)
      4'd0:    s = 7'h3F;
      4'd1:    s = 7'h06;
      4'd2:    s = 7'h5B;
      4'd3:    s = 7'h4F;
      4'd4:    s = 7'h66;
      4'd5:    s = 7'h6D;
      4'd6:    s = 7'h7D;
      4'd7:    s = 7'h07;
      4'd8:    s = 7'h7F;
      4'd9:    s = 7'h6F;
      default: s = SegBlank;
    endcase
    return s;
  endfunction

endpackage

// ===== rtl/svf_in_if.sv =====
// Input channel: valid/ready handshake carrying one value in hundredths.
// Depends on svf_pkg for the field width.
interface svf_in_if import svf_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [ValueW-1:0] value_hundredths;

  modport source (output valid, output value_hundredths, input ready);
  modport sink   (input valid, input value_hundredths, output ready);
endinterface

// ===== rtl/svf_out_if.sv =====
// Output channel: valid/ready handshake carrying one display frame.
// Depends on svf_pkg for the field widths.
interface svf_out_if import svf_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [SelW-1:0] digit_select;
  logic [SegW-1:0] segments;
  logic            decimal_point;
  logic            degree_on;
  logic            last_frame;

  modport source (output valid, output digit_select, output segments,
                  output decimal_point, output degree_on, output last_frame,
                  input ready);
  modport sink   (input valid, input digit_select, input segments,
                  input decimal_point, input degree_on, input last_frame,
                  output ready);
endinterface

// ===== rtl/svf_split.sv =====
// Three-stage digit splitter: saturate, then peel off hundreds, tens and ones.
// Depends on svf_pkg (digit_of, digits_t, widths).
module svf_split import svf_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [ValueW-1:0] in_value,
  output logic              out_valid,
  input  logic              out_ready,
  output digits_t           out_digits
);

  logic              v1, v2, v3;
  logic              adv1, adv2, adv3;
  logic [DigitW-1:0] hun1, hun2, ten2;
  logic [Rem1W-1:0]  rem1;
  logic [Rem2W-1:0]  rem2;
  digits_t           dig3;

  logic [ValueW-1:0] sat;
  logic [DigitW-1:0] hun_c, ten_c, one_c;

  // A stage loads when empty or when its content moves on.
  assign adv3 = !v3 || out_ready;
  assign adv2 = !v2 || adv3;
  assign adv1 = !v1 || adv2;
  assign in_ready = adv1;

  assign sat   = (in_value > SatMax) ? SatMax : in_value;
  assign hun_c = digit_of(sat, Unit10000);
  assign ten_c = digit_of(ValueW'(rem1), Unit1000);
  assign one_c = digit_of(ValueW'(rem2), Unit100);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (adv1) v1 <= in_valid;
      if (adv2) v2 <= v1;
      if (adv3) v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (adv1) begin
      hun1 <= hun_c;
      rem1 <= Rem1W'(sat - ValueW'(hun_c) * Unit10000);
    end
    if (adv2) begin
      hun2 <= hun1;
      ten2 <= ten_c;
      rem2 <= Rem2W'(ValueW'(rem1) - ValueW'(ten_c) * Unit1000);
    end
    if (adv3) begin
      dig3.hun  <= hun2;
      dig3.ten  <= ten2;
      dig3.one  <= one_c;
      dig3.rem3 <= Rem3W'(ValueW'(rem2) - ValueW'(one_c) * Unit100);
    end
  end

  assign out_valid  = v3;
  assign out_digits = dig3;

endmodule

// ===== rtl/svf_frame_gen.sv =====
// Frame builder/serializer: formats digits into four frames, sends one per cycle while ready.
// Depends on svf_pkg and svf_out_if.
module svf_frame_gen import svf_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             mode,
  input  logic             in_valid,
  output logic             in_ready,
  input  digits_t          in_digits,
  svf_out_if.source        out_ch
);

  logic                 busy;
  logic [FrameIdxW-1:0] cnt;
  frame_t               frames [NumFrames];
  frame_t               build  [NumFrames];
  frame_t               cur;
  logic                 out_fire;
  logic                 done;
  logic                 take;

  logic [DigitW-1:0] tth, hth;
  logic [1:0]        shown_hi;  // 2: three integer digits, 1: two, 0: one

  assign tth = digit_of(ValueW'(in_digits.rem3), Unit10);
  assign hth = DigitW'(ValueW'(in_digits.rem3) - ValueW'(tth) * Unit10);

  always_comb begin
    if (in_digits.hun != '0)      shown_hi = 2'd2;
    else if (in_digits.ten != '0) shown_hi = 2'd1;
    else                          shown_hi = 2'd0;
  end

  always_comb begin
    if (mode == ModeTemp) begin
      build[0] = '{sel: 4'b1000, seg: (shown_hi == 2'd2) ? seg_of(in_digits.hun) : SegBlank,
                   dp: 1'b0, deg: 1'b0};
      build[1] = '{sel: 4'b0100, seg: (shown_hi != 2'd0) ? seg_of(in_digits.ten) : SegBlank,
                   dp: 1'b0, deg: 1'b0};
      build[2] = '{sel: 4'b0010, seg: seg_of(in_digits.one), dp: 1'b1, deg: 1'b0};
      build[3] = '{sel: 4'b0001, seg: seg_of(tth), dp: 1'b0, deg: 1'b0};
    end else begin
      build[0] = '{sel: 4'b0000, seg: SegCOnly, dp: 1'b0, deg: 1'b1};
      unique case (shown_hi)
        2'd2: begin
          build[1] = '{sel: 4'b0100, seg: seg_of(in_digits.hun), dp: 1'b0, deg: 1'b0};
          build[2] = '{sel: 4'b0010, seg: seg_of(in_digits.ten), dp: 1'b0, deg: 1'b0};
          build[3] = '{sel: 4'b0001, seg: seg_of(in_digits.one), dp: 1'b0, deg: 1'b0};
        end
        2'd1: begin
          build[1] = '{sel: 4'b0100, seg: seg_of(in_digits.ten), dp: 1'b0, deg: 1'b0};
          build[2] = '{sel: 4'b0010, seg: seg_of(in_digits.one), dp: 1'b1, deg: 1'b0};
          build[3] = '{sel: 4'b0001, seg: seg_of(tth), dp: 1'b0, deg: 1'b0};
        end
        default: begin
          build[1] = '{sel: 4'b0100, seg: seg_of(in_digits.one), dp: 1'b1, deg: 1'b0};
          build[2] = '{sel: 4'b0010, seg: seg_of(tth), dp: 1'b0, deg: 1'b0};
          build[3] = '{sel: 4'b0001, seg: seg_of(hth), dp: 1'b0, deg: 1'b0};
        end
      endcase
    end
  end

  assign out_fire = out_ch.valid && out_ch.ready;
  assign done     = out_fire && (cnt == FrameIdxW'(NumFrames - 1));
  // Take the next transaction as the last frame of the current one leaves.
  assign take     = !busy || done;
  assign in_ready = take;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (take && in_valid) begin
      busy <= 1'b1;
      cnt  <= '0;
    end else if (out_fire) begin
      cnt <= cnt + FrameIdxW'(1);
      if (done) busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take && in_valid) frames <= build;
  end

  assign cur                  = frames[cnt];
  assign out_ch.valid         = busy;
  assign out_ch.digit_select  = cur.sel;
  assign out_ch.segments      = cur.seg;
  assign out_ch.decimal_point = cur.dp;
  assign out_ch.degree_on     = cur.deg;
  assign out_ch.last_frame    = (cnt == FrameIdxW'(NumFrames - 1));

endmodule

// ===== rtl/seven_segment_value_formatter_core.sv =====
// Channel    Dir  Handshake     Payload
// in_ch      in   valid/ready   value_hundredths[16:0]
// out_ch     out  valid/ready   digit_select, segments, decimal_point, degree_on, last_frame
// cfg        in   cfg_write     cfg_data -> display_mode
//
// Each value yields four frames, one per cycle while out_ch.ready is high, so the frame
// serializer's single output port limits how often values are taken.
// A value's first frame is valid after the three split stages and then the frame load.
// The frame builder takes a new value in the cycle the previous value's last frame leaves.
// Output stalls back up through the split stages without losing or repeating a value.
// Reset (rst, synchronous) empties all stages and sets display_mode to temperature.
//
// Top level of the seven-segment value formatter; uses svf_pkg, svf_in_if, svf_out_if,
// svf_split and svf_frame_gen.
module seven_segment_value_formatter_core import svf_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      cfg_write,
  input  logic      cfg_data,
  svf_in_if.sink    in_ch,
  svf_out_if.source out_ch
);

  logic    display_mode;
  logic    split_valid;
  logic    split_ready;
  digits_t split_digits;

  always_ff @(posedge clk) begin
    if (rst) begin
      display_mode <= ModeTemp;
    end else if (cfg_write) begin
      display_mode <= cfg_data;
    end
  end

  svf_split u_split (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_ch.valid),
    .in_ready   (in_ch.ready),
    .in_value   (in_ch.value_hundredths),
    .out_valid  (split_valid),
    .out_ready  (split_ready),
    .out_digits (split_digits)
  );

  svf_frame_gen u_frame_gen (
    .clk       (clk),
    .rst       (rst),
    .mode      (display_mode),
    .in_valid  (split_valid),
    .in_ready  (split_ready),
    .in_digits (split_digits),
    .out_ch    (out_ch)
  );

endmodule

// ===== rtl/svf_checker.sv =====
// Port-level checks on the formatter's output frames, bound to the top level.
// Depends on svf_pkg and seven_segment_value_formatter_core.
module svf_checker import svf_pkg::*; (
  input logic            clk,
  input logic            rst,
  input logic            out_valid,
  input logic            out_ready,
  input logic [SelW-1:0] digit_select,
  input logic [SegW-1:0] segments,
  input logic            decimal_point,
  input logic            degree_on,
  input logic            last_frame
);

  // More frames of the same value follow a frame that is not the last.
  a_frames_continue: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !last_frame |=> out_valid)
    else $error("frame sequence broken before last frame");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(digit_select) && $stable(segments))
    else $error("stalled frame changed");

  a_degree_frame: assert property (@(posedge clk) disable iff (rst)
    out_valid && degree_on |-> digit_select == '0 && segments == SegCOnly && !decimal_point)
    else $error("degree frame malformed");

  a_select_onehot: assert property (@(posedge clk) disable iff (rst)
    out_valid && !degree_on |-> $onehot(digit_select))
    else $error("digit select not one-hot");

  a_last_rightmost: assert property (@(posedge clk) disable iff (rst)
    out_valid && last_frame |-> digit_select == 4'b0001 && !degree_on)
    else $error("last frame not on rightmost digit");

endmodule

bind seven_segment_value_formatter_core svf_checker u_svf_checker (
  .clk           (clk),
  .rst           (rst),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .digit_select  (out_ch.digit_select),
  .segments      (out_ch.segments),
  .decimal_point (out_ch.decimal_point),
  .degree_on     (out_ch.degree_on),
  .last_frame    (out_ch.last_frame)
);

// ===== sim/seven_segment_value_formatter_core_tb.sv =====
// Self-checking testbench for seven_segment_value_formatter_core: predicts the four display
// frames of every accepted value and compares them in order, under random sender/receiver idling.
// Depends on svf_pkg, svf_in_if, svf_out_if and the core RTL.
`timescale 1ns / 1ps

module seven_segment_value_formatter_core_tb import svf_pkg::*; ();

  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned SettleCycles = 8;
  localparam int unsigned PhaseItems = 96;

  typedef struct packed {
    logic [SelW-1:0] sel;
    logic [SegW-1:0] seg;
    logic            dp;
    logic            deg;
    logic            last;
  } display_frame_t;

  typedef enum int unsigned {
    RxAlways,
    RxCoin,
    RxSparse,
    RxPeriodic
  } rx_pattern_t;

  logic clk = 1'b0;
  logic rst;
  logic cfg_write;
  logic cfg_data;

  svf_in_if  in_ch ();
  svf_out_if out_ch ();

  seven_segment_value_formatter_core dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_write(cfg_write),
    .cfg_data (cfg_data),
    .in_ch    (in_ch),
    .out_ch   (out_ch)
  );

  always #4 clk = ~clk;

  display_frame_t pending_frames [$];
  logic [0:0]     display_mode;
  int unsigned    error_count;
  int unsigned    burst_left;
  int unsigned    cycle_count;

  logic [ValueW-1:0] boundary_values [0:11] = '{
    17'd0, 17'd7, 17'd99, 17'd999, 17'd1000, 17'd5678,
    17'd9999, 17'd10000, 17'd12345, 17'd99999, 17'd100000, 17'h1FFFF
  };

  function automatic logic [SegW-1:0] digit_segments(input int unsigned d);
    case (d)
      0:       return 7'h3F;
      1:       return 7'h06;
      2:       return 7'h5B;
      3:       return 7'h4F;
      4:       return 7'h66;
      5:       return 7'h6D;
      6:       return 7'h7D;
      7:       return 7'h07;
      8:       return 7'h7F;
      9:       return 7'h6F;
      default: return SegBlank;
    endcase
  endfunction

  // Expected frames for one value, leftmost position first.
  task automatic queue_display_frames(input logic [ValueW-1:0] raw);
    int unsigned v;
    int unsigned hun, ten, one, tth, hth;
    int unsigned shown, dp_pos, pos;
    int unsigned digs [4];
    display_frame_t fr;
    if (raw > SatMax) v = 32'(SatMax);
    else v = 32'(raw);
    hun = v / 10000;
    ten = (v / 1000) % 10;
    one = (v / 100) % 10;
    tth = (v / 10) % 10;
    hth = v % 10;
    if (display_mode == ModeTemp) begin
      digs = '{hun, ten, one, tth};
      shown = (v >= 10000) ? 4 : (v >= 1000) ? 3 : 2;
      for (int k = 0; k < 4; k++) begin
        pos = 4 - k;
        fr.sel = SelW'(1 << (pos - 1));
        fr.deg = 1'b0;
        fr.last = (k == 3);
        if (pos > shown) begin
          fr.seg = SegBlank;
          fr.dp = 1'b0;
        end else begin
          fr.seg = digit_segments(digs[k]);
          fr.dp = (pos == 2);
        end
        pending_frames.push_back(fr);
      end
    end else begin
      if (v >= 10000) begin
        digs = '{hun, ten, one, 0};
        dp_pos = 0;
      end else if (v >= 1000) begin
        digs = '{ten, one, tth, 0};
        dp_pos = 2;
      end else begin
        digs = '{one, tth, hth, 0};
        dp_pos = 3;
      end
      // Degree lamp frame: no digit selected, segment c only.
      fr = '{sel: '0, seg: SegCOnly, dp: 1'b0, deg: 1'b1, last: 1'b0};
      pending_frames.push_back(fr);
      for (int k = 1; k < 4; k++) begin
        pos = 4 - k;
        fr.sel = SelW'(1 << (pos - 1));
        fr.seg = digit_segments(digs[k-1]);
        fr.dp = (pos == dp_pos);
        fr.deg = 1'b0;
        fr.last = (k == 3);
        pending_frames.push_back(fr);
      end
    end
  endtask

  // Present one value; bursts of back-to-back transactions separated by random gaps.
  task automatic send_value(input logic [ValueW-1:0] v);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_ch.valid <= 1'b1;
    in_ch.value_hundredths <= v;
    do @(posedge clk); while (!in_ch.ready);
    queue_display_frames(v);
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (pending_frames.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic set_display_mode(input logic [0:0] m);
    wait_drained();
    cfg_write <= 1'b1;
    cfg_data <= m;
    @(posedge clk);
    cfg_write <= 1'b0;
    display_mode = m;
  endtask

  function automatic logic [ValueW-1:0] random_value();
    case ($urandom_range(0, 9))
      0, 1, 2: return ValueW'($urandom_range(0, 999));
      3, 4:    return ValueW'($urandom_range(1000, 9999));
      5, 6:    return ValueW'($urandom_range(10000, 99999));
      7:       return ValueW'($urandom_range(100000, 131071));
      8:       return boundary_values[$urandom_range(0, 11)];
      default: return ValueW'($urandom);
    endcase
  endfunction

  // Reset leaves the block in temperature format; no write here.
  task automatic test_temperature_directed();
    foreach (boundary_values[i]) send_value(boundary_values[i]);
  endtask

  task automatic test_angle_directed();
    set_display_mode(ModeAngle);
    foreach (boundary_values[i]) send_value(boundary_values[i]);
  endtask

  task automatic test_random_phases();
    logic [0:0] phase_modes [5];
    phase_modes = '{ModeTemp, ModeAngle, ModeAngle, ModeTemp, 1'($urandom_range(0, 1))};
    foreach (phase_modes[p]) begin
      set_display_mode(phase_modes[p]);
      repeat (PhaseItems) send_value(random_value());
    end
  endtask

  // Output side: check each transaction, then pick ready for the next cycle.
  initial begin
    display_frame_t exp_fr;
    rx_pattern_t pattern;
    int unsigned tick;
    pattern = RxAlways;
    tick = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && out_ch.valid && out_ch.ready) begin
        if (pending_frames.size() == 0) begin
          $error("frame with no value pending: sel %h seg %h", out_ch.digit_select,
                 out_ch.segments);
          error_count++;
        end else begin
          exp_fr = pending_frames.pop_front();
          if (out_ch.digit_select !== exp_fr.sel) begin
            $error("digit_select: expected %h, got %h", exp_fr.sel, out_ch.digit_select);
            error_count++;
          end
          if (out_ch.segments !== exp_fr.seg) begin
            $error("segments: expected %h, got %h", exp_fr.seg, out_ch.segments);
            error_count++;
          end
          if (out_ch.decimal_point !== exp_fr.dp) begin
            $error("decimal_point: expected %b, got %b", exp_fr.dp, out_ch.decimal_point);
            error_count++;
          end
          if (out_ch.degree_on !== exp_fr.deg) begin
            $error("degree_on: expected %b, got %b", exp_fr.deg, out_ch.degree_on);
            error_count++;
          end
          if (out_ch.last_frame !== exp_fr.last) begin
            $error("last_frame: expected %b, got %b", exp_fr.last, out_ch.last_frame);
            error_count++;
          end
        end
      end
      tick++;
      if (tick % 50 == 0) pattern = rx_pattern_t'($urandom_range(0, 3));
      case (pattern)
        RxAlways: out_ch.ready <= 1'b1;
        RxCoin:   out_ch.ready <= 1'($urandom_range(0, 1));
        RxSparse: out_ch.ready <= ($urandom_range(0, 3) == 0);
        default:  out_ch.ready <= (tick % 3 == 0);
      endcase
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CycleLimit) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    error_count = 0;
    burst_left = 0;
    display_mode = ModeTemp;
    rst <= 1'b1;
    cfg_write <= 1'b0;
    cfg_data <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.value_hundredths <= '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_temperature_directed();
    test_angle_directed();
    test_random_phases();

    wait_drained();
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
